### rtl/bdc_pkg.sv
// Shared types and constants for the button debounce / click classifier.
// No dependencies; imported by bdc_core and the top level.
package bdc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int TALLY_W = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW   = 2'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd500;

    // Press tally codes that trigger actions
    localparam logic [TALLY_W-1:0] TALLY_NONE   = 2'd0;
    localparam logic [TALLY_W-1:0] TALLY_FIRST  = 2'd1;
    localparam logic [TALLY_W-1:0] TALLY_SECOND = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_window_ms;
    } bdc_cfg_t;

    typedef struct packed {
        logic               prev_raw;
        logic               stable_level;
        logic [TIME_W-1:0]  change_stamp;
        logic [TIME_W-1:0]  first_press_stamp;
        logic [TALLY_W-1:0] press_tally;
        logic               awaiting_second;
    } bdc_state_t;

    typedef struct packed {
        logic debounced_level;
        logic manual_alert;
        logic false_alarm;
    } bdc_result_t;

endpackage

### rtl/bdc_core.sv
// Per-sample step logic: debounce, press counting and window timeout.
// Purely combinational; depends on bdc_pkg.
module bdc_core
(
    input  bdc_pkg::bdc_cfg_t            cfg,
    input  bdc_pkg::bdc_state_t          state_cur,
    input  logic [bdc_pkg::TIME_W-1:0]   now_ms,
    input  logic                         pin_level,
    output bdc_pkg::bdc_state_t          state_nxt,
    output bdc_pkg::bdc_result_t         result
);
    import bdc_pkg::*;

    logic [TIME_W-1:0]  change_stamp_mid;
    logic [TIME_W-1:0]  since_change;
    logic [TIME_W-1:0]  since_first;
    logic [TALLY_W-1:0] tally_inc;
    logic               take_level;
    logic               press;
    logic               false_flag;
    logic               alert;
    bdc_state_t         mid;

    // Debounce: restart timer on raw change, accept level once steady
    assign change_stamp_mid = (pin_level != state_cur.prev_raw) ? now_ms
                                                                : state_cur.change_stamp;
    assign since_change = now_ms - change_stamp_mid;
    assign take_level   = (since_change > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms})
                          && (pin_level != state_cur.stable_level);
    assign press        = take_level && !pin_level;
    assign tally_inc    = state_cur.press_tally + TALLY_FIRST;

    // Press handling
    always_comb
    begin
        mid              = state_cur;
        mid.prev_raw     = pin_level;
        mid.change_stamp = change_stamp_mid;
        false_flag       = 1'b0;
        if (take_level)
        begin
            mid.stable_level = pin_level;
        end
        if (press)
        begin
            mid.press_tally = tally_inc;
            if (tally_inc == TALLY_FIRST)
            begin
                mid.first_press_stamp = now_ms;
                mid.awaiting_second   = 1'b1;
            end
            else if (tally_inc == TALLY_SECOND)
            begin
                false_flag          = 1'b1;
                mid.press_tally     = TALLY_NONE;
                mid.awaiting_second = 1'b0;
            end
        end
    end

    assign since_first = now_ms - mid.first_press_stamp;

    // Window timeout check, after press handling
    always_comb
    begin
        state_nxt = mid;
        alert     = 1'b0;
        if (mid.awaiting_second
            && (since_first > {{(TIME_W-CFG_W){1'b0}}, cfg.double_window_ms}))
        begin
            alert                     = 1'b1;
            state_nxt.press_tally     = TALLY_NONE;
            state_nxt.awaiting_second = 1'b0;
        end
    end

    assign result = {mid.stable_level, alert, false_flag};

endmodule

### rtl/button_debounce_click_classifier_top.sv
// Button debounce and single/double click classifier, top level.
// Path: input register, then result register, from input transfer to result transfer.
// Throughput: one sample per cycle unless the result stalls; the state update and
// the result register are written together in the single step-logic stage (bdc_core).
// Reset: rst_n async active low; pipeline empty, registers 50 / 500 ms,
// button state released, tally cleared.
// Depends on bdc_pkg and bdc_core.
module button_debounce_click_classifier_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    // config write port
    input  logic                        cfg_we,
    input  logic [bdc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bdc_pkg::CFG_W-1:0]   cfg_data,
    // sample channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bdc_pkg::TIME_W-1:0]  now_ms,
    input  logic                        pin_level,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        debounced_level,
    output logic                        manual_alert,
    output logic                        false_alarm
);
    import bdc_pkg::*;

    bdc_cfg_t          cfg_reg;
    bdc_state_t        state_reg;
    bdc_state_t        state_next;
    bdc_result_t       step_result;
    bdc_result_t       out_reg;
    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_pin_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              s1_adv;
    logic              in_xfer;

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RST;
            cfg_reg.double_window_ms <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DEBOUNCE)
            begin
                cfg_reg.debounce_ms <= cfg_data;
            end
            else if (cfg_index == REG_WINDOW)
            begin
                cfg_reg.double_window_ms <= cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_now_reg <= now_ms;
            s1_pin_reg <= pin_level;
        end
    end

    // Step logic
    bdc_core u_core
    (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .now_ms    (s1_now_reg),
        .pin_level (s1_pin_reg),
        .state_nxt (state_next),
        .result    (step_result)
    );

    // Button state, updated as each sample moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_raw          <= 1'b1;
            state_reg.stable_level      <= 1'b1;
            state_reg.change_stamp      <= '0;
            state_reg.first_press_stamp <= '0;
            state_reg.press_tally       <= TALLY_NONE;
            state_reg.awaiting_second   <= 1'b0;
        end
        else if (s1_adv)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign debounced_level = out_reg.debounced_level;
    assign manual_alert    = out_reg.manual_alert;
    assign false_alarm     = out_reg.false_alarm;

    // Checks
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.manual_alert && out_reg.false_alarm))
        else $error("manual_alert and false_alarm raised together");

    a_await_matches_tally: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.awaiting_second == (state_reg.press_tally == TALLY_FIRST))
        else $error("awaiting_second out of step with press tally");

    a_tally_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.press_tally != 2'd3)
        else $error("press tally reached an unused value");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(state_reg))
        else $error("button state changed without a sample moving");

endmodule

### test/tb.sv
// Testbench for button_debounce_click_classifier_top: debounce and click flags.
// A queue-fed driver and a checking monitor run against an in-bench predictor.
// Depends on bdc_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
    import bdc_pkg::*;

    // Writes to these indexes must be ignored by the block
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int SETTLE_CYCLES = 4;     // covers the input and result registers
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 3000;  // watchdog, cycles with no transfer
    localparam int PHASE_ITEMS   = 220;

    typedef struct {
        logic [TIME_W-1:0] stamp;
        logic              pin;
    } sample_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [TIME_W-1:0] now_ms = '0;
    logic              pin_level = 1'b1;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              debounced_level;
    logic              manual_alert;
    logic              false_alarm;

    button_debounce_click_classifier_top i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_ms          (now_ms),
        .pin_level       (pin_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .debounced_level (debounced_level),
        .manual_alert    (manual_alert),
        .false_alarm     (false_alarm)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sample_t     pending_samples[$];
    bdc_result_t predicted_flags[$];
    int          mismatches = 0;

    // Predictor copy of the block's registers and button state
    bdc_cfg_t    model_cfg;
    bdc_state_t  button;

    // Stimulus generator bookkeeping
    logic [TIME_W-1:0] stim_ms = '0;
    logic              stim_pin = 1'b1;
    logic [TIME_W-1:0] stim_edge_ms = '0;

    // Receiver hold-off request
    int hold_seq = 0;

    // Predict the flags for one accepted sample and advance the button state
    task automatic classify_sample(input logic [TIME_W-1:0] stamp, input logic pin,
                                   output bdc_result_t res);
        logic [TIME_W-1:0] steady_for;
        logic [TIME_W-1:0] since_first;
        res = '0;
        if (pin != button.prev_raw)
            button.change_stamp = stamp;
        steady_for = stamp - button.change_stamp;
        if (steady_for > TIME_W'(model_cfg.debounce_ms) && pin != button.stable_level)
        begin
            button.stable_level = pin;
            if (!button.stable_level)
            begin
                button.press_tally = button.press_tally + 2'd1;
                if (button.press_tally == TALLY_FIRST)
                begin
                    button.first_press_stamp = stamp;
                    button.awaiting_second   = 1'b1;
                end
                else if (button.press_tally == TALLY_SECOND)
                begin
                    res.false_alarm        = 1'b1;
                    button.press_tally     = TALLY_NONE;
                    button.awaiting_second = 1'b0;
                end
            end
        end
        // window timeout is checked after press handling
        since_first = stamp - button.first_press_stamp;
        if (button.awaiting_second && since_first > TIME_W'(model_cfg.double_window_ms))
        begin
            res.manual_alert       = 1'b1;
            button.press_tally     = TALLY_NONE;
            button.awaiting_second = 1'b0;
        end
        button.prev_raw = pin;
        res.debounced_level = button.stable_level;
    endtask

    task automatic push_sample(input logic [TIME_W-1:0] stamp, input logic pin);
        sample_t s;
        s.stamp = stamp;
        s.pin   = pin;
        pending_samples.push_back(s);
        if (pin != stim_pin)
            stim_edge_ms = stamp;
        stim_pin = pin;
        stim_ms  = stamp;
    endtask

    // Drive the pin to a level with bounce, then hold it past the debounce time.
    // Returns the stamp at which the level should be accepted.
    task automatic settle_level(input logic level, input logic [TIME_W-1:0] db,
                                output logic [TIME_W-1:0] accepted_at);
        int bounces;
        bounces = $urandom_range(0, 3);
        for (int i = 0; i < bounces; i++)
            push_sample(stim_ms + $urandom_range(0, db), (i % 2 == 0) ? level : ~level);
        push_sample(stim_ms + $urandom_range(0, db), level);
        // right on the debounce boundary: not yet accepted
        if ($urandom_range(0, 2) == 0)
            push_sample(stim_edge_ms + db, level);
        accepted_at = stim_edge_ms + db + 1 + $urandom_range(0, 20);
        push_sample(accepted_at, level);
        repeat ($urandom_range(0, 2))
            push_sample(stim_ms + $urandom_range(0, db + 5), level);
    endtask

    // One press and release, followed by a gap sized against the window
    task automatic gen_click(input logic [TIME_W-1:0] db, input logic [TIME_W-1:0] win);
        logic [TIME_W-1:0] press_ms;
        logic [TIME_W-1:0] release_ms;
        settle_level(1'b0, db, press_ms);
        settle_level(1'b1, db, release_ms);
        case ($urandom_range(0, 3))
            0: stim_ms = stim_ms + $urandom_range(0, win / 4);
            1: push_sample(press_ms + win + $urandom_range(0, 1), 1'b1);
            2: stim_ms = stim_ms + win + $urandom_range(0, win + 100);
            default: stim_ms = stim_ms + $urandom_range(0, win + 10);
        endcase
    endtask

    task automatic gen_click_stream(input int count);
        int base;
        logic [TIME_W-1:0] db;
        logic [TIME_W-1:0] win;
        db   = TIME_W'(model_cfg.debounce_ms);
        win  = TIME_W'(model_cfg.double_window_ms);
        base = pending_samples.size();
        while (pending_samples.size() - base < count)
        begin
            case ($urandom_range(0, 9))
                // unrelated noise samples
                0: repeat ($urandom_range(1, 4))
                       push_sample($urandom, 1'($urandom_range(0, 1)));
                // broken sequence: timestamps stepping backwards
                1: push_sample(stim_ms - $urandom_range(0, 2 * db + 2),
                               1'($urandom_range(0, 1)));
                // move close to the counter wrap
                2: stim_ms = 32'hFFFF_FFFF - $urandom_range(0, db + win + 2);
                default: gen_click(db, win);
            endcase
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || predicted_flags.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_DEBOUNCE)
            model_cfg.debounce_ms = val;
        else if (idx == REG_WINDOW)
            model_cfg.double_window_ms = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sample driver: bursts of random length with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk)
    begin
        sample_t     nxt;
        bdc_result_t res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                classify_sample(now_ms, pin_level, res);
                predicted_flags.push_back(res);
            end
            if (in_valid && in_stall)
            begin
                // payload held while stalled
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                nxt = pending_samples.pop_front();
                in_valid  <= 1'b1;
                now_ms    <= nxt.stamp;
                pin_level <= nxt.pin;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, plus a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(5, 60);
            out_stall  <= 1'b0;
        end
        else
        begin
            mode_left <= mode_left - 1;
            case (stall_mode)
                1: out_stall <= ($urandom_range(0, 7) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                3: out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        bdc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_flags.size() == 0)
            begin
                $display("%0t: result transfer with nothing predicted", $time);
                mismatches++;
            end
            else
            begin
                want = predicted_flags.pop_front();
                if (debounced_level !== want.debounced_level)
                begin
                    $display("%0t: debounced_level expected %0b actual %0b",
                             $time, want.debounced_level, debounced_level);
                    mismatches++;
                end
                if (manual_alert !== want.manual_alert)
                begin
                    $display("%0t: manual_alert expected %0b actual %0b",
                             $time, want.manual_alert, manual_alert);
                    mismatches++;
                end
                if (false_alarm !== want.false_alarm)
                begin
                    $display("%0t: false_alarm expected %0b actual %0b",
                             $time, want.false_alarm, false_alarm);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sequence: reset, directed samples, then random phases per setting
    initial
    begin
        int db;
        int win;
        model_cfg.debounce_ms      = DEBOUNCE_RST;
        model_cfg.double_window_ms = WINDOW_RST;
        button.prev_raw          = 1'b1;
        button.stable_level      = 1'b1;
        button.change_stamp      = '0;
        button.first_press_stamp = '0;
        button.press_tally       = TALLY_NONE;
        button.awaiting_second   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings (50 / 500)
        push_sample(32'd0, 1'b1);
        push_sample(32'd10, 1'b0);
        push_sample(32'd60, 1'b0);     // steady exactly the debounce time
        push_sample(32'd61, 1'b0);     // first press
        push_sample(32'd100, 1'b1);
        push_sample(32'd151, 1'b1);
        push_sample(32'd200, 1'b0);
        push_sample(32'd251, 1'b0);    // second press inside window
        push_sample(32'd300, 1'b1);
        push_sample(32'd351, 1'b1);
        push_sample(32'd400, 1'b0);
        push_sample(32'd451, 1'b0);
        push_sample(32'd460, 1'b1);
        push_sample(32'd511, 1'b1);
        push_sample(32'd951, 1'b1);    // window exactly used up
        push_sample(32'd952, 1'b1);    // timeout: single press
        push_sample(32'd1000, 1'b0);
        push_sample(32'd1051, 1'b0);
        push_sample(32'd1060, 1'b1);
        push_sample(32'd1111, 1'b1);
        push_sample(32'd1540, 1'b0);
        push_sample(32'd1700, 1'b0);   // late second press, no timeout seen
        push_sample(32'd1705, 1'b1);
        push_sample(32'd1703, 1'b1);   // time going backwards
        push_sample(32'hFFFF_FFF0, 1'b0);
        push_sample(32'h0000_0030, 1'b0); // press across the counter wrap

        for (int ph = 1; ph <= 7; ph++)
        begin
            wait_idle();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (ph)
                1: begin db = 0;     win = 0;     end
                2: begin db = 65535; win = 65535; end
                3: begin db = 0;     win = 65535; end
                4: begin db = 65535; win = 0;     end
                default:
                begin
                    db  = $urandom_range(1, 60);
                    win = $urandom_range(2 * db + 4, 900);
                end
            endcase
            write_reg(REG_DEBOUNCE, CFG_W'(db));
            write_reg(REG_WINDOW, CFG_W'(win));
            if (ph == 3)
            begin
                write_reg(REG_SPARE_LO, CFG_W'($urandom));
                write_reg(REG_SPARE_HI, CFG_W'($urandom));
            end
            @(negedge clk);
            if (ph == 5)
                hold_seq++;
            gen_click_stream(PHASE_ITEMS);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### button_debounce_click_classifier_top.f
rtl/bdc_pkg.sv
rtl/bdc_core.sv
rtl/button_debounce_click_classifier_top.sv
test/tb.sv
